// File: design/dmkt_pkg.sv
// ----------------------------------------------------------------------------
// dmkt_pkg
// Shared widths, codes and the probe record for the direct mapped key table.
// ----------------------------------------------------------------------------
package dmkt_pkg;

   localparam int SLOTS_DEF = 16;
   localparam int MODE_W    = 2;
   localparam int KEY_W     = 40;
   localparam int NAME_W    = 64;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 4;

   localparam int REQ_W     = 112;
   localparam int RSP_W     = 72;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_FIND   = 2'd1,
      MODE_DELETE = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_COLLISION = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_DELETED   = 3'd4
   } status_type;

   typedef struct packed {
      logic                active;
      logic                done;
      mode_type            mode;
      logic [KEY_W-1:0]    key;
      logic [NAME_W-1:0]   name;
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [NAME_W-1:0]   found_name;
   } probe_type;

endpackage

// File: design/dmkt_hash.sv
// ----------------------------------------------------------------------------
// dmkt_hash
// Key modulo SLOTS by byte folding and reciprocal multiply; launches one probe
// into the cell chain.
// ----------------------------------------------------------------------------
module dmkt_hash #(
   parameter int SLOTS = dmkt_pkg::SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  dmkt_pkg::mode_type            mode,
   input  logic [dmkt_pkg::KEY_W-1:0]    key,
   input  logic [dmkt_pkg::NAME_W-1:0]   entry_name,
   output dmkt_pkg::probe_type           probe_out,
   output logic [$clog2(SLOTS)-1:0]      hash_out
);
   import dmkt_pkg::*;

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int FOLD_W = 19;
   localparam logic [7:0]        WT0     = 8'(64'd1 % SLOTS);
   localparam logic [7:0]        WT1     = 8'(64'd256 % SLOTS);
   localparam logic [7:0]        WT2     = 8'(64'd65536 % SLOTS);
   localparam logic [7:0]        WT3     = 8'(64'd16777216 % SLOTS);
   localparam logic [7:0]        WT4     = 8'(64'd4294967296 % SLOTS);
   localparam logic [FOLD_W-1:0] RECIP   = FOLD_W'((64'd1 << FOLD_W) / SLOTS);
   localparam logic [FOLD_W-1:0] DIV_VAL = FOLD_W'(SLOTS);

   logic                s1_ff,    s1_in;
   logic                s2_ff,    s2_in;
   logic                s3_ff,    s3_in;
   mode_type            mode_ff,  mode_in;
   logic [KEY_W-1:0]    key_ff,   key_in;
   logic [NAME_W-1:0]   name_ff,  name_in;
   logic [FOLD_W-1:0]   fold_ff,  fold_in;
   logic [FOLD_W-1:0]   quot_ff,  quot_in;
   probe_type           probe_ff, probe_in;
   logic [IDX_W-1:0]    hash_ff,  hash_in;
   logic [15:0]         part0, part1, part2, part3, part4;
   logic [2*FOLD_W-1:0] prod;
   logic [FOLD_W-1:0]   back;
   logic [FOLD_W-1:0]   rem;

   always_comb begin
      s1_in   = start;
      s2_in   = s1_ff;
      s3_in   = s2_ff;
      mode_in = mode_ff;
      key_in  = key_ff;
      name_in = name_ff;
      if (start) begin
         mode_in = mode;
         key_in  = key;
         name_in = entry_name;
      end

      // fold each key byte by its weight 256**i modulo SLOTS
      part0   = {8'd0, key_ff[7:0]}   * {8'd0, WT0};
      part1   = {8'd0, key_ff[15:8]}  * {8'd0, WT1};
      part2   = {8'd0, key_ff[23:16]} * {8'd0, WT2};
      part3   = {8'd0, key_ff[31:24]} * {8'd0, WT3};
      part4   = {8'd0, key_ff[39:32]} * {8'd0, WT4};
      fold_in = {{(FOLD_W-16){1'b0}}, part0} + {{(FOLD_W-16){1'b0}}, part1} +
                {{(FOLD_W-16){1'b0}}, part2} + {{(FOLD_W-16){1'b0}}, part3} +
                {{(FOLD_W-16){1'b0}}, part4};

      // quotient may fall one short; fix the remainder with one subtract
      prod    = {{FOLD_W{1'b0}}, fold_ff} * {{FOLD_W{1'b0}}, RECIP};
      quot_in = prod[2*FOLD_W-1:FOLD_W];
      back    = quot_ff * DIV_VAL;
      rem     = fold_ff - back;
      hash_in = (rem >= DIV_VAL) ? IDX_W'(rem - DIV_VAL) : IDX_W'(rem);

      probe_in.active     = s3_ff;
      probe_in.done       = 1'b0;
      probe_in.mode       = mode_ff;
      probe_in.key        = key_ff;
      probe_in.name       = name_ff;
      probe_in.status     = ST_NOT_FOUND;
      probe_in.slot       = '0;
      probe_in.found_name = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff           <= 1'b0;
         s2_ff           <= 1'b0;
         s3_ff           <= 1'b0;
         probe_ff.active <= 1'b0;
      end else begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         s3_ff    <= s3_in;
         probe_ff <= probe_in;
      end
      mode_ff <= mode_in;
      key_ff  <= key_in;
      name_ff <= name_in;
      fold_ff <= fold_in;
      quot_ff <= quot_in;
      hash_ff <= hash_in;
   end

   assign probe_out = probe_ff;
   assign hash_out  = hash_ff;

endmodule

// File: design/dmkt_cell.sv
// ----------------------------------------------------------------------------
// dmkt_cell
// One table slot; serves the passing probe and hands it to the next cell.
// ----------------------------------------------------------------------------
module dmkt_cell #(
   parameter int SLOTS = dmkt_pkg::SLOTS_DEF,
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dmkt_pkg::probe_type           probe_in,
   input  logic [$clog2(SLOTS)-1:0]      hash_in,
   output dmkt_pkg::probe_type           probe_out,
   output logic [$clog2(SLOTS)-1:0]      hash_out
);
   import dmkt_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0]  MY_IDX  = IDX_W'(INDEX);
   localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

   logic                valid_ff, valid_in;
   logic [KEY_W-1:0]    key_ff,   key_in;
   logic [NAME_W-1:0]   name_ff,  name_in;
   probe_type           probe_ff, probe_nx;
   logic [IDX_W-1:0]    hash_ff;
   logic                hit;

   always_comb begin
      hit      = valid_ff && (key_ff == probe_in.key);
      probe_nx = probe_in;
      valid_in = valid_ff;
      key_in   = key_ff;
      name_in  = name_ff;
      if (probe_in.active && !probe_in.done) begin
         unique case (probe_in.mode)
            MODE_INSERT: begin
               if (hash_in == MY_IDX) begin
                  probe_nx.done = 1'b1;
                  probe_nx.slot = MY_SLOT;
                  if (valid_ff) begin
                     probe_nx.status = ST_COLLISION;
                  end else begin
                     probe_nx.status = ST_INSERTED;
                     valid_in        = 1'b1;
                     key_in          = probe_in.key;
                     name_in         = probe_in.name;
                  end
               end
            end
            MODE_FIND: begin
               if (hit) begin
                  probe_nx.done       = 1'b1;
                  probe_nx.slot       = MY_SLOT;
                  probe_nx.status     = ST_FOUND;
                  probe_nx.found_name = name_ff;
               end
            end
            MODE_DELETE: begin
               if (hit) begin
                  probe_nx.done   = 1'b1;
                  probe_nx.slot   = MY_SLOT;
                  probe_nx.status = ST_DELETED;
                  valid_in        = 1'b0;
               end
            end
            default: begin
               probe_nx.done = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         probe_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         probe_ff <= probe_nx;
      end
      key_ff  <= key_in;
      name_ff <= name_in;
      hash_ff <= hash_in;
   end

   assign probe_out = probe_ff;
   assign hash_out  = hash_ff;

endmodule

// File: design/direct_mapped_key_table_top.sv
// ----------------------------------------------------------------------------
// direct_mapped_key_table_top
// Keyed table of SLOTS entries: insert by key modulo SLOTS, find, delete.
// Path: the key, fold, quotient and hash registers for the key modulo, a
// register in each slot cell, then the output register to response valid.
// Requests: one at a time; a new one is accepted only once the previous
// response reaches the output register, and a response held past the next one's arrival stalls the request side.
// Reset: synchronous; clears every valid bit at once, table ready as soon as reset is released.
// ----------------------------------------------------------------------------
module direct_mapped_key_table_top #(
   parameter int SLOTS = dmkt_pkg::SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // mode[1:0], key[41:2], entry_name[105:42], zero fill
   input  logic [dmkt_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // status[2:0], slot[6:3], found_name[70:7], zero fill
   output logic [dmkt_pkg::RSP_W-1:0]  rsp_tdata
);
   import dmkt_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);

   probe_type           probe_chain [0:SLOTS];
   logic [IDX_W-1:0]    hash_chain  [0:SLOTS];

   logic                busy_ff,      busy_in;
   logic                pend_vld_ff,  pend_vld_in;
   probe_type           pend_ff,      pend_in;
   logic                rsp_vld_ff,   rsp_vld_in;
   probe_type           rsp_ff,       rsp_in;
   logic                accept;
   logic                rsp_free;

   assign req_tready = !busy_ff && !reset;
   assign accept     = req_tvalid && req_tready;

   dmkt_hash #(.SLOTS(SLOTS)) u_hash (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .mode       (mode_type'(req_tdata[1:0])),
      .key        (req_tdata[41:2]),
      .entry_name (req_tdata[105:42]),
      .probe_out  (probe_chain[0]),
      .hash_out   (hash_chain[0])
   );

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      dmkt_cell #(.SLOTS(SLOTS), .INDEX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .probe_in  (probe_chain[i]),
         .hash_in   (hash_chain[i]),
         .probe_out (probe_chain[i+1]),
         .hash_out  (hash_chain[i+1])
      );
   end

   always_comb begin
      rsp_free    = !rsp_vld_ff || rsp_tready;
      busy_in     = busy_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_in      = rsp_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      priority if (pend_vld_ff && rsp_free) begin
         rsp_in      = pend_ff;
         rsp_vld_in  = 1'b1;
         pend_vld_in = 1'b0;
         busy_in     = 1'b0;
      end else if (probe_chain[SLOTS].active && rsp_free) begin
         rsp_in     = probe_chain[SLOTS];
         rsp_vld_in = 1'b1;
         busy_in    = 1'b0;
      end else if (probe_chain[SLOTS].active) begin
         pend_in     = probe_chain[SLOTS];
         pend_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.found_name, rsp_ff.slot, rsp_ff.status};

endmodule

// File: tb/tb_direct_mapped_key_table_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_direct_mapped_key_table_top
// Self-checking bench for the direct mapped key table. A mirror of the table
// predicts the reply to every accepted request and checks each reply in order.
// Traffic is a directed pass over the corner cases, then random insert, find,
// delete and unused mode traffic under sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_direct_mapped_key_table_top;
   import dmkt_pkg::*;

   localparam int TABLE_SLOTS  = SLOTS_DEF;
   localparam int LATENCY      = TABLE_SLOTS + 4;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int ITEMS_PHASE  = 160;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [KEY_W-1:0]  KEY_MAX     = {KEY_W{1'b1}};
   localparam logic [NAME_W-1:0] NAME_ONES   = {NAME_W{1'b1}};

   typedef struct {
      status_type         status;
      logic [SLOT_W-1:0]  slot;
      logic [NAME_W-1:0]  found_name;
   } table_reply_type;

   class table_mirror_type;
      bit                 live[TABLE_SLOTS];
      logic [KEY_W-1:0]   keys[TABLE_SLOTS];
      logic [NAME_W-1:0]  names[TABLE_SLOTS];
      table_reply_type    pending_replies[$];
      int                 errors;
      int                 requests;
      int                 status_seen[5];

      function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                 logic [NAME_W-1:0] name);
         table_reply_type r;
         int              home;
         int              hit;
         home = int'(key % TABLE_SLOTS);
         hit  = -1;
         for (int i = TABLE_SLOTS - 1; i >= 0; i--)
            if (live[i] && keys[i] == key) hit = i;
         r.status     = ST_NOT_FOUND;
         r.slot       = '0;
         r.found_name = '0;
         case (mode)
            MODE_INSERT: begin
               r.slot = home[SLOT_W-1:0];
               if (live[home]) begin
                  r.status = ST_COLLISION;
               end else begin
                  r.status    = ST_INSERTED;
                  live[home]  = 1'b1;
                  keys[home]  = key;
                  names[home] = name;
               end
            end
            MODE_FIND: begin
               if (hit >= 0) begin
                  r.status     = ST_FOUND;
                  r.slot       = hit[SLOT_W-1:0];
                  r.found_name = names[hit];
               end
            end
            MODE_DELETE: begin
               if (hit >= 0) begin
                  r.status  = ST_DELETED;
                  r.slot    = hit[SLOT_W-1:0];
                  live[hit] = 1'b0;
               end
            end
            default: ;
         endcase
         requests++;
         pending_replies.push_back(r);
      endfunction

      function void check_reply(logic [RSP_W-1:0] data);
         table_reply_type   want;
         status_type        got_status;
         logic [SLOT_W-1:0] got_slot;
         logic [NAME_W-1:0] got_name;
         got_status = status_type'(data[2:0]);
         got_slot   = data[6:3];
         got_name   = data[70:7];
         if (pending_replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected reply, expected none, actual %h", $time, data);
            return;
         end
         want = pending_replies.pop_front();
         if (got_status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got_status);
         end
         if (got_slot !== want.slot) begin
            errors++;
            $display("%0t: slot mismatch, expected %0d, actual %0d",
                     $time, want.slot, got_slot);
         end
         if (got_name !== want.found_name) begin
            errors++;
            $display("%0t: found_name mismatch, expected %h, actual %h",
                     $time, want.found_name, got_name);
         end
         if (want.status <= ST_DELETED) status_seen[want.status]++;
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;

   table_mirror_type   mirror;
   int                 req_idle_pct;
   int                 rsp_stall_pct;
   bit                 hold_req;
   int                 hold_left;
   int                 cycle_count;
   logic [KEY_W-1:0]   key_pool[16];

   direct_mapped_key_table_top #(.SLOTS(TABLE_SLOTS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) mirror.check_reply(rsp_tdata);
   end

   initial begin
      rsp_tready = 1'b0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                               logic [NAME_W-1:0] name);
      int gap;
      gap = 0;
      if (req_idle_pct > 0 && $urandom_range(99) < 3) gap = $urandom_range(80, 1);
      while ($urandom_range(99) < req_idle_pct) gap++;
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - MODE_W - KEY_W - NAME_W){1'b0}}, name, key, mode};
      do @(posedge clock); while (!req_tready);
      mirror.note_request(mode, key, name);
   endtask

   task automatic drain_table();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (mirror.pending() > 0);
   endtask

   function automatic logic [KEY_W-1:0] fresh_key();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(9))
         0: return '0;
         1: return KEY_MAX;
         default: return raw[KEY_W-1:0];
      endcase
   endfunction

   task automatic random_request();
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key;
      logic [NAME_W-1:0] name;
      int                pick;
      pick = $urandom_range(99);
      if (pick < 5) mode = MODE_UNUSED;
      else if (pick < 40) mode = MODE_INSERT;
      else if (pick < 75) mode = MODE_FIND;
      else mode = MODE_DELETE;
      if ($urandom_range(99) < 70) begin
         key = key_pool[$urandom_range(15)];
      end else begin
         key = fresh_key();
         if (mode == MODE_INSERT) key_pool[$urandom_range(15)] = key;
      end
      case ($urandom_range(19))
         0: name = '0;
         1: name = NAME_ONES;
         default: name = {$urandom, $urandom};
      endcase
      send_request(mode, key, name);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, bit hold_off);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      if (hold_off) hold_req = 1'b1;
      repeat (ITEMS_PHASE) random_request();
      drain_table();
   endtask

   initial begin
      mirror        = new();
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_req      = 1'b0;
      cycle_count   = 0;
      foreach (key_pool[i]) key_pool[i] = fresh_key();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(MODE_FIND,   '0,          '0);
      send_request(MODE_INSERT, '0,          '0);
      send_request(MODE_INSERT, KEY_MAX,     NAME_ONES);
      send_request(MODE_INSERT, 40'd16,      64'h0123_4567_89AB_CDEF);
      send_request(MODE_INSERT, '0,          NAME_ONES);
      send_request(MODE_FIND,   '0,          '0);
      send_request(MODE_FIND,   KEY_MAX,     '0);
      send_request(MODE_FIND,   40'd16,      '0);
      send_request(MODE_UNUSED, '0,          NAME_ONES);
      send_request(MODE_FIND,   '0,          '0);
      send_request(MODE_DELETE, KEY_MAX,     NAME_ONES);
      send_request(MODE_FIND,   KEY_MAX,     '0);
      send_request(MODE_DELETE, KEY_MAX,     '0);
      send_request(MODE_INSERT, 40'd31,      64'h4A4F_484E_534D_4954);
      send_request(MODE_FIND,   40'd31,      '0);
      send_request(MODE_DELETE, '0,          '0);
      send_request(MODE_INSERT, 40'd16,      64'hFEDC_BA98_7654_3210);
      send_request(MODE_FIND,   40'd16,      '0);
      send_request(MODE_INSERT, 40'h55_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(MODE_INSERT, 40'hAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      send_request(MODE_FIND,   40'h55_5555_5555, '0);
      send_request(MODE_FIND,   40'hAA_AAAA_AAAA, '0);
      send_request(MODE_DELETE, 40'd16,      '0);
      send_request(MODE_FIND,   40'd16,      '0);
      drain_table();

      run_phase(0,  0,  1'b0);
      run_phase(51, 0,  1'b0);
      run_phase(0,  51, 1'b1);
      run_phase(20, 20, 1'b0);

      repeat (2 * LATENCY) @(posedge clock);
      $display("Covered %0d requests under four idle/stall mixes and a %0d-cycle output hold.",
               mirror.requests, HOLD_CYCLES);
      $display("Replies: %0d inserted, %0d collision, %0d found, %0d not found, %0d deleted.",
               mirror.status_seen[ST_INSERTED], mirror.status_seen[ST_COLLISION],
               mirror.status_seen[ST_FOUND], mirror.status_seen[ST_NOT_FOUND],
               mirror.status_seen[ST_DELETED]);
      if (mirror.errors == 0 && mirror.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
